/* design/goldbach_odd_prime_pair_defines.svh */
// assertion macros for the goldbach prime pair block
`ifndef GOLDBACH_ODD_PRIME_PAIR_DEFINES_SVH
`define GOLDBACH_ODD_PRIME_PAIR_DEFINES_SVH

`ifndef SYNTHESIS

`define GBOPP_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("goldbach prime pair assertion failed");

`define GBOPP_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error("goldbach prime pair forbidden condition seen");

`else

`define GBOPP_ASSERT(lbl, clk_s, rstn_s, prop)

`define GBOPP_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)

`endif

`endif

/* design/gbopp_pkg.sv */
package gbopp_pkg;

    // first candidate and first trial divisor
    localparam int unsigned FIRST_ODD_PRIME = 3;
    // stride between odd values
    localparam int unsigned ODD_STEP        = 2;
    // square of the first trial divisor
    localparam int unsigned FIRST_SQUARE    = FIRST_ODD_PRIME * FIRST_ODD_PRIME;

endpackage

/* design/goldbach_odd_prime_pair.sv */
// goldbach prime pair search
// input channel: number with in_valid / in_stall. in_stall is high while a
// number is being searched, so one item is in work at a time.
// output channel: number_echo, small_prime, large_prime with out_valid /
// out_stall. an odd number, zero, two, four or an even number without a pair
// gives no item on the output.
// candidates p = 3, 5, 7, ... are tried in order; p and number - p are each
// tested by trial division with odd divisors d while d*d <= value. every
// remainder comes out of a bit-serial restoring divider, one bit per cycle.
// the time taken is data dependent: an odd number is dropped at the edge that
// takes it, and the search time of an even number is set by the number of
// divisor trials through the serial divider.
// the result sits in an output register, so a new number is taken while a
// finished result still waits. if the output register is still full when the
// next search ends, the search holds until out_stall drops.
// reset empties the output register and returns the block to idle.
`include "goldbach_odd_prime_pair_defines.svh"

module goldbach_odd_prime_pair #(
    parameter int unsigned NUM_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [NUM_WIDTH-1:0] number,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NUM_WIDTH-1:0] number_echo,
    output logic [NUM_WIDTH-1:0] small_prime,
    output logic [NUM_WIDTH-1:0] large_prime
);
    import gbopp_pkg::*;

    localparam int unsigned CW    = NUM_WIDTH + 1;
    localparam int unsigned SW    = NUM_WIDTH + 2;
    localparam int unsigned CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_INIT,
        ST_CHECK,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t               state_reg, state_next;
    logic [NUM_WIDTH-1:0] num_reg, num_next;
    logic [CW-1:0]        cand_reg, cand_next;
    logic                 phase_reg, phase_next;
    logic [NUM_WIDTH-1:0] val_reg, val_next;
    logic [NUM_WIDTH-1:0] div_reg, div_next;
    logic [SW-1:0]        sq_reg, sq_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NUM_WIDTH-1:0] echo_reg, echo_next;
    logic [NUM_WIDTH-1:0] small_reg, small_next;
    logic [NUM_WIDTH-1:0] large_reg, large_next;

    // one step of the restoring divider
    logic [CW-1:0]        trial;
    logic [CW-1:0]        trial_diff;
    logic [NUM_WIDTH-1:0] rem_step;

    assign trial      = {rem_reg, sh_reg[NUM_WIDTH-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign rem_step   = (trial >= {1'b0, div_reg}) ? trial_diff[NUM_WIDTH-1:0]
                                                   : trial[NUM_WIDTH-1:0];

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign number_echo = echo_reg;
    assign small_prime = small_reg;
    assign large_prime = large_reg;

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        cand_next      = cand_reg;
        phase_next     = phase_reg;
        val_next       = val_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        echo_next      = echo_reg;
        small_next     = small_reg;
        large_next     = large_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    num_next  = number;
                    cand_next = CW'(FIRST_ODD_PRIME);
                    // odd numbers have no odd prime pair
                    if (!number[0])
                    begin
                        state_next = ST_CAND;
                    end
                end
            end
            ST_CAND:
            begin
                if (cand_reg > {1'b0, num_reg})
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    val_next   = cand_reg[NUM_WIDTH-1:0];
                    phase_next = 1'b0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (val_reg < NUM_WIDTH'(ODD_STEP))
                begin
                    cand_next  = cand_reg + CW'(ODD_STEP);
                    state_next = ST_CAND;
                end
                else
                begin
                    div_next   = NUM_WIDTH'(FIRST_ODD_PRIME);
                    sq_next    = SW'(FIRST_SQUARE);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > {2'b00, val_reg})
                begin
                    // no divisor found, value is prime
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        val_next   = num_reg - cand_reg[NUM_WIDTH-1:0];
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
                else
                begin
                    rem_next   = '0;
                    sh_next    = val_reg;
                    cnt_next   = CNT_W'(NUM_WIDTH - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                sh_next  = {sh_reg[NUM_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (rem_step == '0)
                    begin
                        cand_next  = cand_reg + CW'(ODD_STEP);
                        state_next = ST_CAND;
                    end
                    else
                    begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        sq_next    = sq_reg + {div_reg, 2'b00} + SW'(4);
                        div_next   = div_reg + NUM_WIDTH'(ODD_STEP);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    echo_next      = num_reg;
                    small_next     = cand_reg[NUM_WIDTH-1:0];
                    large_next     = num_reg - cand_reg[NUM_WIDTH-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_reg       <= '0;
            cand_reg      <= '0;
            phase_reg     <= 1'b0;
            val_reg       <= '0;
            div_reg       <= '0;
            sq_reg        <= '0;
            rem_reg       <= '0;
            sh_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            echo_reg      <= '0;
            small_reg     <= '0;
            large_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            num_reg       <= num_next;
            cand_reg      <= cand_next;
            phase_reg     <= phase_next;
            val_reg       <= val_next;
            div_reg       <= div_next;
            sq_reg        <= sq_next;
            rem_reg       <= rem_next;
            sh_reg        <= sh_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            echo_reg      <= echo_next;
            small_reg     <= small_next;
            large_reg     <= large_next;
        end
    end

    // a result always splits its number into two odd parts
    `GBOPP_ASSERT(a_pair_sum, clk, rst_n,
        out_valid_reg |-> (({1'b0, small_reg} + {1'b0, large_reg}) == {1'b0, echo_reg}))
    `GBOPP_ASSERT(a_pair_odd, clk, rst_n,
        out_valid_reg |-> (small_reg[0] && large_reg[0] && !echo_reg[0]))
    // an odd number is dropped at once
    `GBOPP_ASSERT(a_odd_drop, clk, rst_n,
        (in_valid && !in_stall && number[0]) |=> (state_reg == ST_IDLE))
    // divider remainder stays below the divisor
    `GBOPP_ASSERT(a_rem_range, clk, rst_n,
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
    // candidates are always odd while searching
    `GBOPP_ASSERT_NEVER(a_cand_even, clk, rst_n,
        (state_reg != ST_IDLE) && !cand_reg[0])

endmodule
